[src/tnsb_pkg.sv]
// tnsb_pkg: shared types, constants and saturating helpers for the step bound core
// no dependencies; imported by tnsb_ctrl, tnsb_dp and the top level
package tnsb_pkg;

  localparam int FracBits  = 16;
  localparam int DivSteps  = 64 + FracBits;
  localparam int SqrtSteps = 32;
  localparam int CntW      = $clog2(DivSteps);

  localparam logic [31:0] InitStepReset = 32'h0001_0000;
  localparam logic [31:0] OneFix        = 32'(1) << FracBits;

  localparam logic signed [63:0] SMax = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SMin = {1'b1, {63{1'b0}}};

  // product sequence: pairs of cross terms, then b*b and a*c
  localparam logic [3:0] PrA0 = 4'd0;
  localparam logic [3:0] PrA1 = 4'd1;
  localparam logic [3:0] PrB0 = 4'd2;
  localparam logic [3:0] PrB1 = 4'd3;
  localparam logic [3:0] PrE0 = 4'd4;
  localparam logic [3:0] PrE1 = 4'd5;
  localparam logic [3:0] PrC0 = 4'd6;
  localparam logic [3:0] PrC1 = 4'd7;
  localparam logic [3:0] PrBB = 4'd8;
  localparam logic [3:0] PrAC = 4'd9;

  typedef enum logic [1:0] {
    DvLeft  = 2'd0,
    DvRight = 2'd1,
    DvNegA  = 2'd2,
    DvZeroA = 2'd3
  } div_sel_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic               last_vertex;
  } in_item_t;

  typedef struct packed {
    logic [31:0] step_size;
    logic        error;
  } out_item_t;

  typedef struct packed {
    logic       store_corner;
    logic       corner_slot;
    logic       open_mesh;
    logic       load_in;
    logic       diff;
    logic       mul;
    logic       add;
    logic       form;
    logic       comb;
    logic [3:0] prod;
    logic [1:0] part;
    logic       bsum;
    logic       sq_init;
    logic       sq_step;
    logic       dv_init;
    logic       dv_load;
    logic       dv_step;
    logic       dv_done;
    div_sel_e   dv_sel;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic a_pos;
    logic a_neg;
    logic b_neg;
    logic d_pos;
    logic out_busy;
  } sts_t;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] x,
                                                   input logic signed [63:0] y);
    logic signed [64:0] s;
    s = {x[63], x} + {y[63], y};
    if (s[64] != s[63]) begin
      sat_add64 = s[64] ? SMin : SMax;
    end else begin
      sat_add64 = s[63:0];
    end
  endfunction

  function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] x,
                                                   input logic signed [63:0] y);
    logic signed [64:0] s;
    s = {x[63], x} - {y[63], y};
    if (s[64] != s[63]) begin
      sat_sub64 = s[64] ? SMin : SMax;
    end else begin
      sat_sub64 = s[63:0];
    end
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    mag64 = x[63] ? (~x + 64'd1) : x;
  endfunction

endpackage

[src/tnsb_ctrl.sv]
// tnsb_ctrl: sequencer for corner intake, product schedule, sqrt and divide passes
// depends on tnsb_pkg; drives tnsb_dp through cmd_t and reads sts_t
module tnsb_ctrl import tnsb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [13:0] {
    SIdle = 14'b00000000000001,
    SDiff = 14'b00000000000010,
    SMul  = 14'b00000000000100,
    SAdd  = 14'b00000000001000,
    SForm = 14'b00000000010000,
    SComb = 14'b00000000100000,
    SBsum = 14'b00000001000000,
    SSqi  = 14'b00000010000000,
    SSqrt = 14'b00000100000000,
    SDvi  = 14'b00001000000000,
    SDvl  = 14'b00010000000000,
    SDiv  = 14'b00100000000000,
    SDvd  = 14'b01000000000000,
    SFin  = 14'b10000000000000
  } state_e;

  state_e          state_q, state_d;
  logic [1:0]      cc_q, cc_d;
  logic            open_q, open_d;
  logic            last_q, last_d;
  logic [3:0]      prod_q, prod_d;
  logic [1:0]      part_q, part_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  div_sel_e        sel_q, sel_d;
  logic            accept;
  logic [1:0]      last_part;
  state_e          done_state;

  assign in_ready_o = (state_q == SIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign last_part  = (prod_q == PrBB || prod_q == PrAC) ? 2'd3 : 2'd0;
  assign done_state = last_q ? SFin : SIdle;

  always_comb begin
    state_d = state_q;
    cc_d    = cc_q;
    open_d  = open_q;
    last_d  = last_q;
    prod_d  = prod_q;
    part_d  = part_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.prod   = prod_q;
    cmd_o.part   = part_q;
    cmd_o.dv_sel = sel_q;
    case (state_q)
      SIdle: begin
        if (accept) begin
          if (!open_q) begin
            cmd_o.open_mesh = 1'b1;
            open_d          = 1'b1;
          end
          if (cc_q < 2'd2) begin
            cmd_o.store_corner = 1'b1;
            cmd_o.corner_slot  = cc_q[0];
            cc_d               = cc_q + 2'd1;
          end else begin
            cmd_o.load_in = 1'b1;
            cc_d          = 2'd0;
            last_d        = in_last_i;
            state_d       = SDiff;
          end
        end
      end
      SDiff: begin
        cmd_o.diff = 1'b1;
        prod_d     = PrA0;
        part_d     = 2'd0;
        state_d    = SMul;
      end
      SMul: begin
        cmd_o.mul = 1'b1;
        state_d   = SAdd;
      end
      SAdd: begin
        cmd_o.add = 1'b1;
        if (part_q == last_part) begin
          state_d = SForm;
        end else begin
          part_d  = part_q + 2'd1;
          state_d = SMul;
        end
      end
      SForm: begin
        cmd_o.form = 1'b1;
        state_d    = SComb;
      end
      SComb: begin
        cmd_o.comb = 1'b1;
        part_d     = 2'd0;
        if (prod_q == PrC1) begin
          state_d = SBsum;
        end else if (prod_q == PrAC) begin
          state_d = SSqi;
        end else begin
          prod_d  = prod_q + 4'd1;
          state_d = SMul;
        end
      end
      SBsum: begin
        cmd_o.bsum = 1'b1;
        prod_d     = PrBB;
        state_d    = SMul;
      end
      SSqi: begin
        cmd_o.sq_init = 1'b1;
        cnt_d         = '0;
        state_d       = SSqrt;
      end
      SSqrt: begin
        cmd_o.sq_step = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == CntW'(SqrtSteps - 1)) begin
          // pick which roots this triangle needs
          if (sts_i.a_pos) begin
            if (sts_i.b_neg && sts_i.d_pos) begin
              sel_d   = DvLeft;
              state_d = SDvi;
            end else begin
              state_d = done_state;
            end
          end else if (sts_i.a_neg) begin
            sel_d   = DvNegA;
            state_d = SDvi;
          end else if (sts_i.b_neg) begin
            sel_d   = DvZeroA;
            state_d = SDvi;
          end else begin
            state_d = done_state;
          end
        end
      end
      SDvi: begin
        cmd_o.dv_init = 1'b1;
        state_d       = SDvl;
      end
      SDvl: begin
        cmd_o.dv_load = 1'b1;
        cnt_d         = '0;
        state_d       = SDiv;
      end
      SDiv: begin
        cmd_o.dv_step = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = SDvd;
        end
      end
      SDvd: begin
        cmd_o.dv_done = 1'b1;
        if (sel_q == DvLeft) begin
          sel_d   = DvRight;
          state_d = SDvi;
        end else begin
          state_d = done_state;
        end
      end
      SFin: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          open_d     = 1'b0;
          state_d    = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cc_q    <= 2'd0;
      open_q  <= 1'b0;
      last_q  <= 1'b0;
      prod_q  <= PrA0;
      part_q  <= 2'd0;
      cnt_q   <= '0;
      sel_q   <= DvLeft;
    end else begin
      state_q <= state_d;
      cc_q    <= cc_d;
      open_q  <= open_d;
      last_q  <= last_d;
      prod_q  <= prod_d;
      part_q  <= part_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
    end
  end

endmodule

[src/tnsb_dp.sv]
// tnsb_dp: corner store, shared 32x32 multiplier, quadratic terms, sqrt and divide units
// depends on tnsb_pkg; sequenced by tnsb_ctrl
module tnsb_dp import tnsb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    in_item_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o
);

  logic signed [31:0] hp_q [4];
  logic signed [31:0] hd_q [4];
  in_item_t           in_q;

  logic signed [32:0] u2x_q, u2y_q, u3x_q, u3y_q, v2x_q, v2y_q, v3x_q, v3y_q;

  logic [63:0]        pp_q;
  logic [127:0]       acc_q;
  logic signed [63:0] p_q, t_q, a_q, b_q, c_q, e_q, dl_q, nb_q;

  logic [63:0]        rad_q;
  logic [33:0]        rem_q;
  logic [31:0]        root_q;

  logic signed [63:0] num_q, den_q;
  logic [DivSteps-1:0] dvn_q;
  logic [63:0]        dmag_q;
  logic [64:0]        r_q;
  logic [31:0]        q_q;
  logic               ovf_q;

  logic [31:0]        init_q, run_q, left_q, right_q;
  logic               err_q;
  logic               out_valid_q;
  out_item_t          out_q;

  // operand selection for the shared multiplier
  logic [63:0] opx_m, opy_m;
  logic        opx_s, opy_s;

  function automatic logic [63:0] dmag33(input logic signed [32:0] v);
    logic [32:0] n;
    n = v[32] ? (~v + 33'd1) : v;
    dmag33 = {32'd0, n[31:0]};
  endfunction

  always_comb begin
    opx_m = dmag33(v2x_q);
    opy_m = dmag33(v3y_q);
    opx_s = v2x_q[32];
    opy_s = v3y_q[32];
    case (cmd_i.prod)
      PrA0: begin
        opx_m = dmag33(v2x_q); opx_s = v2x_q[32];
        opy_m = dmag33(v3y_q); opy_s = v3y_q[32];
      end
      PrA1: begin
        opx_m = dmag33(v2y_q); opx_s = v2y_q[32];
        opy_m = dmag33(v3x_q); opy_s = v3x_q[32];
      end
      PrB0: begin
        opx_m = dmag33(u2x_q); opx_s = u2x_q[32];
        opy_m = dmag33(v3y_q); opy_s = v3y_q[32];
      end
      PrB1: begin
        opx_m = dmag33(u2y_q); opx_s = u2y_q[32];
        opy_m = dmag33(v3x_q); opy_s = v3x_q[32];
      end
      PrE0: begin
        opx_m = dmag33(v2x_q); opx_s = v2x_q[32];
        opy_m = dmag33(u3y_q); opy_s = u3y_q[32];
      end
      PrE1: begin
        opx_m = dmag33(v2y_q); opx_s = v2y_q[32];
        opy_m = dmag33(u3x_q); opy_s = u3x_q[32];
      end
      PrC0: begin
        opx_m = dmag33(u2x_q); opx_s = u2x_q[32];
        opy_m = dmag33(u3y_q); opy_s = u3y_q[32];
      end
      PrC1: begin
        opx_m = dmag33(u2y_q); opx_s = u2y_q[32];
        opy_m = dmag33(u3x_q); opy_s = u3x_q[32];
      end
      PrBB: begin
        opx_m = mag64(b_q); opx_s = b_q[63];
        opy_m = mag64(b_q); opy_s = b_q[63];
      end
      PrAC: begin
        opx_m = mag64(a_q); opx_s = a_q[63];
        opy_m = mag64(c_q); opy_s = c_q[63];
      end
      default: begin
        opx_m = '0;
        opy_m = '0;
        opx_s = 1'b0;
        opy_s = 1'b0;
      end
    endcase
  end

  logic [31:0]  xh, yh;
  logic [1:0]   pp_pos;
  logic [127:0] pp_sh;
  logic [6:0]   fsh;
  logic [127:0] acc_sh;
  logic [63:0]  pmag;
  logic         pneg;
  logic signed [63:0] pval;
  logic signed [63:0] sfix;

  assign xh     = cmd_i.part[0] ? opx_m[63:32] : opx_m[31:0];
  assign yh     = cmd_i.part[1] ? opy_m[63:32] : opy_m[31:0];
  assign pp_pos = {1'b0, cmd_i.part[0]} + {1'b0, cmd_i.part[1]};
  assign pp_sh  = {64'd0, pp_q} << {pp_pos, 5'd0};
  assign fsh    = (cmd_i.prod == PrBB) ? 7'(2 * FracBits) :
                  (cmd_i.prod == PrAC) ? 7'(2 * FracBits - 2) : 7'd0;
  assign acc_sh = acc_q >> fsh;
  assign pmag   = (|acc_sh[127:64]) ? {64{1'b1}} : acc_sh[63:0];
  assign pneg   = opx_s ^ opy_s;
  assign sfix   = {{(32 - FracBits){1'b0}}, root_q, {FracBits{1'b0}}};

  always_comb begin
    if (!pneg) begin
      pval = pmag[63] ? SMax : pmag;
    end else begin
      pval = pmag[63] ? SMin : (~pmag + 64'd1);
    end
  end

  // sqrt: two radicand bits per step
  logic [35:0] sq_cur, sq_trial;
  assign sq_cur   = {rem_q, rad_q[63:62]};
  assign sq_trial = {2'b00, root_q, 2'b01};

  // divide: one quotient bit per step
  logic [65:0] dv_rr;
  logic        dv_ge;
  logic [31:0] dv_res;
  logic        dv_zero;
  logic [DivSteps-1:0] dv_ext;
  assign dv_rr   = {r_q, dvn_q[DivSteps-1]};
  assign dv_ge   = dv_rr >= {2'b00, dmag_q};
  assign dv_res  = ovf_q ? {32{1'b1}} : q_q;
  assign dv_zero = (num_q == '0) || (num_q[63] != den_q[63]);
  assign dv_ext  = {{FracBits{1'b0}}, (dv_zero ? 64'd0 : mag64(num_q))};

  logic [31:0] fin_step;
  always_comb begin
    fin_step = run_q;
    if (run_q < right_q && run_q > left_q) begin
      fin_step = left_q;
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_corner) begin
      if (cmd_i.corner_slot) begin
        hp_q[2] <= in_item_i.pos_x;
        hp_q[3] <= in_item_i.pos_y;
        hd_q[2] <= in_item_i.dir_x;
        hd_q[3] <= in_item_i.dir_y;
      end else begin
        hp_q[0] <= in_item_i.pos_x;
        hp_q[1] <= in_item_i.pos_y;
        hd_q[0] <= in_item_i.dir_x;
        hd_q[1] <= in_item_i.dir_y;
      end
    end
    if (cmd_i.load_in) begin
      in_q <= in_item_i;
    end
    if (cmd_i.diff) begin
      u2x_q <= {hp_q[2][31], hp_q[2]} - {hp_q[0][31], hp_q[0]};
      u2y_q <= {hp_q[3][31], hp_q[3]} - {hp_q[1][31], hp_q[1]};
      u3x_q <= {in_q.pos_x[31], in_q.pos_x} - {hp_q[0][31], hp_q[0]};
      u3y_q <= {in_q.pos_y[31], in_q.pos_y} - {hp_q[1][31], hp_q[1]};
      v2x_q <= {hd_q[2][31], hd_q[2]} - {hd_q[0][31], hd_q[0]};
      v2y_q <= {hd_q[3][31], hd_q[3]} - {hd_q[1][31], hd_q[1]};
      v3x_q <= {in_q.dir_x[31], in_q.dir_x} - {hd_q[0][31], hd_q[0]};
      v3y_q <= {in_q.dir_y[31], in_q.dir_y} - {hd_q[1][31], hd_q[1]};
    end
    if (cmd_i.mul) begin
      pp_q <= xh * yh;
    end
    if (cmd_i.add) begin
      acc_q <= ((cmd_i.part == 2'd0) ? 128'd0 : acc_q) + pp_sh;
    end
    if (cmd_i.form) begin
      p_q <= pval;
    end
    if (cmd_i.comb) begin
      case (cmd_i.prod)
        PrA1:    a_q  <= sat_sub64(t_q, p_q);
        PrB1:    b_q  <= sat_sub64(t_q, p_q);
        PrE1:    e_q  <= sat_sub64(t_q, p_q);
        PrC1:    c_q  <= sat_sub64(t_q, p_q);
        PrAC:    dl_q <= sat_sub64(t_q, p_q);
        default: t_q  <= p_q;
      endcase
    end
    if (cmd_i.bsum) begin
      b_q <= sat_add64(b_q, e_q);
    end
    if (cmd_i.sq_init) begin
      rad_q  <= (!dl_q[63] && dl_q != '0) ? dl_q : 64'd0;
      rem_q  <= '0;
      root_q <= '0;
      nb_q   <= sat_sub64(64'sd0, b_q);
    end
    if (cmd_i.sq_step) begin
      rad_q <= {rad_q[61:0], 2'b00};
      if (sq_cur >= sq_trial) begin
        rem_q  <= 34'(sq_cur - sq_trial);
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= sq_cur[33:0];
        root_q <= {root_q[30:0], 1'b0};
      end
    end
    if (cmd_i.dv_init) begin
      case (cmd_i.dv_sel)
        DvRight: begin
          num_q <= sat_add64(nb_q, sfix);
          den_q <= a_q;
        end
        DvZeroA: begin
          num_q <= sat_sub64(64'sd0, c_q);
          den_q <= b_q;
        end
        default: begin
          num_q <= sat_sub64(nb_q, sfix);
          den_q <= a_q;
        end
      endcase
    end
    if (cmd_i.dv_load) begin
      dvn_q  <= (cmd_i.dv_sel == DvZeroA) ? (dv_ext << FracBits)
                                          : (dv_ext << (FracBits - 1));
      dmag_q <= mag64(den_q);
      r_q    <= '0;
      q_q    <= '0;
      ovf_q  <= 1'b0;
    end
    if (cmd_i.dv_step) begin
      dvn_q <= {dvn_q[DivSteps-2:0], 1'b0};
      ovf_q <= ovf_q | q_q[31];
      if (dv_ge) begin
        r_q <= 65'(dv_rr - {2'b00, dmag_q});
        q_q <= {q_q[30:0], 1'b1};
      end else begin
        r_q <= dv_rr[64:0];
        q_q <= {q_q[30:0], 1'b0};
      end
    end
    if (cmd_i.emit) begin
      out_q.step_size <= fin_step;
      out_q.error     <= err_q || (fin_step == 32'd0);
    end
  end

  // mesh state, config and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q      <= InitStepReset;
      run_q       <= InitStepReset;
      left_q      <= OneFix;
      right_q     <= 32'd0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        init_q <= cfg_wdata_i;
      end
      if (cmd_i.open_mesh) begin
        run_q <= init_q;
      end
      if (cmd_i.sq_init) begin
        if (c_q[63] || c_q == '0 || (a_q[63] && (dl_q[63] || dl_q == '0))) begin
          err_q <= 1'b1;
        end
      end
      if (cmd_i.dv_done) begin
        case (cmd_i.dv_sel)
          DvLeft: begin
            if (dv_res < left_q) left_q <= dv_res;
          end
          DvRight: begin
            if (dv_res > right_q) right_q <= dv_res;
          end
          default: begin
            if (dv_res < run_q) run_q <= dv_res;
          end
        endcase
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        run_q       <= init_q;
        left_q      <= OneFix;
        right_q     <= 32'd0;
        err_q       <= 1'b0;
      end
    end
  end

  assign sts_o.a_pos    = !a_q[63] && (a_q != '0);
  assign sts_o.a_neg    = a_q[63];
  assign sts_o.b_neg    = b_q[63];
  assign sts_o.d_pos    = !dl_q[63] && (dl_q != '0);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[src/triangle_noninversion_step_bound_core.sv]
// triangle_noninversion_step_bound_core: top level, sequencer plus datapath
// depends on tnsb_pkg, tnsb_ctrl, tnsb_dp
//
//   port group      direction  transfer when
//   in_item_i       in         in_valid_i && in_ready_o
//   out_item_o      out        out_valid_o && out_ready_i
//   cfg_wdata_i     in         cfg_we_i (initial_step)
//
// corners one and two of a triangle are only stored; ready stays high after each
// the third corner keeps ready low until its triangle is done: 10 products
// on one shared 32x32 multiplier, a 32-step square root and up to two 80-step divisions
// rst_ni clears the sequencer, the mesh state and initial_step to 1.0
// a waiting result does not block intake; only the close of a later mesh waits
module triangle_noninversion_step_bound_core import tnsb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;

  tnsb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_item_i.last_vertex),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tnsb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[tb/triangle_step_checker.sv]
// triangle_step_checker: watches the item, result and register ports of the step bound core,
// predicts each closing step and compares it field by field; depends on tnsb_pkg
`timescale 1ns / 100ps

module triangle_step_checker import tnsb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_item_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          corners_o,
  output int          steps_o,
  output int          flagged_o
);

  localparam longint SatHi = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SatLo = 64'sh8000_0000_0000_0000;
  localparam logic [31:0] UnitStep = 32'(1) << FracBits;

  out_item_t          expected_steps[$];
  logic [31:0]        start_step;
  logic [1:0]         corner_cnt;
  logic signed [31:0] held_pos[4];
  logic signed [31:0] held_dir[4];
  logic [31:0]        cur_step;
  logic [31:0]        span_left;
  logic [31:0]        span_right;
  logic               flag_seen;
  logic               mesh_live;

  function automatic longint unsigned absval(longint x);
    return x < 0 ? longint'(-x) : x;
  endfunction

  function automatic longint clamp_signed(bit neg, longint unsigned m);
    if (!neg) return (m > longint'(SatHi)) ? SatHi : longint'(m);
    if (m[63]) return SatLo;
    return -longint'(m);
  endfunction

  function automatic longint sat_plus(longint x, longint y);
    longint r;
    r = x + y;
    if (x[63] == y[63] && r[63] != x[63]) return x[63] ? SatLo : SatHi;
    return r;
  endfunction

  function automatic longint sat_minus(longint x, longint y);
    longint r;
    r = x - y;
    if (x[63] != y[63] && r[63] != x[63]) return x[63] ? SatLo : SatHi;
    return r;
  endfunction

  // exact product, magnitude shifted down, saturated back to 64 bits
  function automatic longint scaled_product(longint x, longint y, int s);
    logic [127:0] p;
    longint unsigned m;
    p = {64'd0, absval(x)} * {64'd0, absval(y)};
    p = p >> s;
    m = (p[127:64] != 0) ? '1 : p[63:0];
    return clamp_signed((x < 0) != (y < 0), m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [31:0] frac_quot(longint unsigned n, longint unsigned d, int sh);
    logic [127:0] q;
    if (d == 0) return '1;
    q = ({64'd0, n} << sh) / {64'd0, d};
    return (q > 128'hFFFF_FFFF) ? '1 : q[31:0];
  endfunction

  function automatic logic [31:0] flip_root(longint num, longint den, int sh);
    if (num == 0 || ((num < 0) != (den < 0))) return '0;
    return frac_quot(absval(num), absval(den), sh);
  endfunction

  function automatic longint cross2(longint px, longint py, longint qx, longint qy);
    return sat_minus(scaled_product(px, qy, 0), scaled_product(py, qx, 0));
  endfunction

  task automatic clear_mesh();
    corner_cnt = 0;
    cur_step   = start_step;
    span_left  = UnitStep;
    span_right = '0;
    flag_seen  = 1'b0;
    mesh_live  = 1'b0;
  endtask

  task automatic bound_triangle(in_item_t it);
    longint u2x, u2y, u3x, u3y, v2x, v2y, v3x, v3y;
    longint qa, qb, qc, disc, root_d, nb;
    logic [31:0] bound, lo_r, hi_r;
    u2x = longint'(held_pos[2]) - longint'(held_pos[0]);
    u2y = longint'(held_pos[3]) - longint'(held_pos[1]);
    u3x = longint'(it.pos_x) - longint'(held_pos[0]);
    u3y = longint'(it.pos_y) - longint'(held_pos[1]);
    v2x = longint'(held_dir[2]) - longint'(held_dir[0]);
    v2y = longint'(held_dir[3]) - longint'(held_dir[1]);
    v3x = longint'(it.dir_x) - longint'(held_dir[0]);
    v3y = longint'(it.dir_y) - longint'(held_dir[1]);
    qa = cross2(v2x, v2y, v3x, v3y);
    qb = sat_plus(cross2(u2x, u2y, v3x, v3y), cross2(v2x, v2y, u3x, u3y));
    qc = cross2(u2x, u2y, u3x, u3y);
    disc = sat_minus(scaled_product(qb, qb, 2 * FracBits),
                     scaled_product(qa, qc, 2 * FracBits - 2));
    root_d = (disc > 0) ? longint'(int_sqrt(disc) << FracBits) : 0;
    nb = sat_minus(0, qb);
    bound = cur_step;
    if (qc <= 0) flag_seen = 1'b1;
    if (qa > 0) begin
      if (qb < 0 && disc > 0) begin
        lo_r = flip_root(sat_minus(nb, root_d), qa, FracBits - 1);
        hi_r = flip_root(sat_plus(nb, root_d), qa, FracBits - 1);
        if (lo_r < span_left) span_left = lo_r;
        if (hi_r > span_right) span_right = hi_r;
      end
    end else if (qa < 0) begin
      // no real root: flagged, bound taken with a zero root term
      if (disc <= 0) flag_seen = 1'b1;
      bound = flip_root(sat_minus(nb, root_d), qa, FracBits - 1);
    end else if (qb < 0) begin
      bound = flip_root(sat_minus(0, qc), qb, FracBits);
    end
    if (bound < cur_step) cur_step = bound;
  endtask

  task automatic take_corner(in_item_t it);
    out_item_t res;
    int k;
    if (!mesh_live) begin
      cur_step  = start_step;
      mesh_live = 1'b1;
    end
    if (corner_cnt < 2) begin
      k = corner_cnt[0] ? 2 : 0;
      held_pos[k] = it.pos_x;
      held_pos[k + 1] = it.pos_y;
      held_dir[k] = it.dir_x;
      held_dir[k + 1] = it.dir_y;
      corner_cnt++;
    end else begin
      bound_triangle(it);
      corner_cnt = 0;
      // last flag on an early corner is ignored
      if (it.last_vertex) begin
        res.step_size = cur_step;
        if (cur_step < span_right && cur_step > span_left) res.step_size = span_left;
        res.error = flag_seen || (res.step_size == 0);
        expected_steps.push_back(res);
        clear_mesh();
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      expected_steps.delete();
      start_step = InitStepReset;
      clear_mesh();
      for (int i = 0; i < 4; i++) begin
        held_pos[i] = '0;
        held_dir[i] = '0;
      end
      mismatches_o <= 0;
      pending_o    <= 0;
      corners_o    <= 0;
      steps_o      <= 0;
      flagged_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        steps_o <= steps_o + 1;
        if (out_item_i.error) flagged_o <= flagged_o + 1;
        if (expected_steps.size() == 0) begin
          if (mismatches_o < 10)
            $display("unexpected result: step_size %h error %b",
                     out_item_i.step_size, out_item_i.error);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = expected_steps.pop_front();
          if (want.step_size !== out_item_i.step_size || want.error !== out_item_i.error) begin
            if (mismatches_o < 10)
              $display("step mismatch: expected step_size %h error %b, got step_size %h error %b",
                       want.step_size, want.error, out_item_i.step_size, out_item_i.error);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        take_corner(in_item_i);
        corners_o <= corners_o + 1;
      end
      if (cfg_we_i) start_step = cfg_wdata_i;
      pending_o <= expected_steps.size();
    end
  end

endmodule

[tb/triangle_noninversion_step_bound_core_test.sv]
// triangle_noninversion_step_bound_core_test: stimulus, handshake pacing and verdict
// depends on tnsb_pkg, triangle_noninversion_step_bound_core and triangle_step_checker
`timescale 1ns / 100ps

module triangle_noninversion_step_bound_core_test;
  import tnsb_pkg::*;

  localparam int One        = 65536;
  localparam int StallLimit = 40000;
  localparam int HoldCycles = 3000;
  localparam int SettleWait = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  int mismatches, pending, corners, steps, flagged;
  int burst_left = 0;
  int idle_cycles = 0;
  int phase_corners;
  bit hold_req = 0;
  bit hold_done = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  triangle_noninversion_step_bound_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o, .cfg_we_i, .cfg_wdata_i
  );

  triangle_step_checker checker_u (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_item_i(out_item_o),
    .cfg_we_i, .cfg_wdata_i,
    .mismatches_o(mismatches), .pending_o(pending), .corners_o(corners),
    .steps_o(steps), .flagged_o(flagged)
  );

  // receiver: long hold when requested, otherwise a drifting stall pattern
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 1) == 0);
          2: out_ready_i <= ($urandom_range(0, 7) != 0);
          default: out_ready_i <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no transfer for %0d cycles", StallLimit);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_corner(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] dx, logic signed [31:0] dy, logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 4) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_item_i  <= '{pos_x: px, pos_y: py, dir_x: dx, dir_y: dy, last_vertex: last};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    phase_corners++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_start_step(logic [31:0] v);
    drain_results();
    repeat (SettleWait) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    phase_corners = 0;
  endtask

  function automatic logic signed [31:0] near(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic send_mesh(int ntri);
    logic signed [31:0] x0, y0, w, h, u;
    int dspan;
    for (int t = 0; t < ntri; t++) begin
      if ($urandom_range(0, 9) == 0) begin
        // raw 32-bit corners drive the saturating paths
        send_corner($urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
        send_corner($urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
        send_corner($urandom, $urandom, $urandom, $urandom, t == ntri - 1);
      end else begin
        x0 = near(100 * One);
        y0 = near(100 * One);
        w  = $urandom_range(One / 4, 4 * One);
        h  = $urandom_range(One / 4, 4 * One);
        u  = near(2 * One);
        if ($urandom_range(0, 7) == 0) h = -h;
        dspan = ($urandom_range(0, 3) == 0) ? 8 * One : One;
        send_corner(x0, y0, near(dspan), near(dspan), $urandom_range(0, 9) == 0);
        send_corner(x0 + w, y0, near(dspan), near(dspan), $urandom_range(0, 9) == 0);
        send_corner(x0 + u, y0 + h, near(dspan), near(dspan), t == ntri - 1);
      end
    end
  endtask

  initial begin
    logic [31:0] start_vals[5];
    start_vals = '{32'd1, 32'hFFFF_FFFF, 32'h0003_0000, 32'h0, 32'h0000_8000};
    start_vals[3] = $urandom_range(1, 32'hFFFF_FFFF);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    write_start_step(32'h0001_0000);
    // static triangle, bound stays at the start step
    send_corner(0, 0, 0, 0, 1'b0);
    send_corner(One, 0, 0, 0, 1'b0);
    send_corner(0, One, 0, 0, 1'b1);
    // linear collapse, a is zero and b negative
    send_corner(0, 0, 0, 0, 1'b0);
    send_corner(One, 0, -2 * One, 0, 1'b0);
    send_corner(0, One, 0, 0, 1'b1);
    // negative a
    send_corner(0, 0, 0, 0, 1'b0);
    send_corner(One, 0, -2 * One, 0, 1'b0);
    send_corner(0, One, 0, 2 * One, 1'b1);
    // positive a with two real roots
    send_corner(0, 0, 0, 0, 1'b0);
    send_corner(One, 0, -3 * One, 0, 1'b0);
    send_corner(0, 2 * One, 0, -One, 1'b1);
    // inverted start triangle
    send_corner(0, 0, 0, 0, 1'b0);
    send_corner(0, One, 0, 0, 1'b0);
    send_corner(One, 0, One, One, 1'b1);
    // field extremes, early last flags ignored
    send_corner(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    send_corner(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
    send_corner(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    send_corner(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    send_corner(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    send_corner(0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);

    for (int p = 0; p < 6; p++) begin
      write_start_step(p < 5 ? start_vals[p] : $urandom);
      if (p == 1) hold_req = 1;
      while (phase_corners < 285) begin
        send_mesh($urandom_range(1, 4));
        if (p == 2 && phase_corners > 140 && phase_corners < 150) drain_results();
      end
    end

    drain_results();
    repeat (SettleWait) @(posedge clk_i);
    $display("run covered %0d corners and %0d closing steps (%0d flagged), six start steps",
             corners, steps, flagged);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[triangle_noninversion_step_bound_core.f]
src/tnsb_pkg.sv
src/tnsb_ctrl.sv
src/tnsb_dp.sv
src/triangle_noninversion_step_bound_core.sv
tb/triangle_step_checker.sv
tb/triangle_noninversion_step_bound_core_test.sv
